@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker file of the zone table.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is applied.
`define ZST_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define ZST_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/zst_pkg.sv @@
// Shared types, codes and defaults of the zone table.
// Used by every module and interface of the block; depends on nothing.
package zst_pkg;

  localparam int MapEntriesDef = 4096;
  localparam int MaxZonesDef   = 16;
  localparam int TagBitsDef    = 16;
  localparam int AddrBits      = 12;

  localparam logic [12:0] RESET_ZONE_BLOCKS = 13'd256;
  localparam logic [4:0]  RESET_ZONE_COUNT  = 5'd16;

  localparam logic CFG_ZONE_BLOCKS = 1'b0;
  localparam logic CFG_ZONE_COUNT  = 1'b1;

  localparam logic [1:0] STATUS_OK     = 2'd0;
  localparam logic [1:0] STATUS_NO_TAG = 2'd1;
  localparam logic [1:0] STATUS_RANGE  = 2'd2;

  localparam logic [1:0] KIND_UNUSED = 2'd0;
  localparam logic [1:0] KIND_BUFFER = 2'd1;
  localparam logic [1:0] KIND_ZONE   = 2'd2;

  typedef enum logic [2:0] {
    OP_RESET       = 3'd0,
    OP_OPEN_IMP    = 3'd1,
    OP_OPEN_EXP    = 3'd2,
    OP_CLOSE       = 3'd3,
    OP_FINISH      = 3'd4,
    OP_OFFLINE     = 3'd5,
    OP_APPEND_BUF  = 3'd6,
    OP_APPEND_ZONE = 3'd7
  } opcode_e;

  typedef enum logic [2:0] {
    ZS_EMPTY    = 3'd0,
    ZS_OPEN_IMP = 3'd1,
    ZS_OPEN_EXP = 3'd2,
    ZS_CLOSED   = 3'd3,
    ZS_FULL     = 3'd4,
    ZS_OFFLINE  = 3'd5
  } zone_state_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic        all_zones;
    logic [11:0] block_addr;
    logic [3:0]  zone_index;
    logic [12:0] block_count;
    logic [15:0] buffer_tag;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  zone_state;
    logic [12:0] buffer_pointer;
    logic [12:0] zone_pointer;
    logic [1:0]  entry_kind;
    logic [12:0] entry_block;
    logic [15:0] entry_tag;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic div_step;
    logic sweep_start;
    logic sweep_step;
    logic apply;
    logic read;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic sweep_done;
    logic sa_all;
    logic act;
    logic need_sweep;
  } dp_stat_t;

endpackage

@@ hdl/zst_stream_if.sv @@
// Valid/ready channel that carries one request or one result.
// The payload type comes from zst_pkg.
interface zst_stream_if #(
  parameter type T = zst_pkg::req_t
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ hdl/zst_ctrl.sv @@
// Controller state machine of the zone table.
// Sequences the datapath through commands; uses types of zst_pkg.
module zst_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  zst_pkg::dp_stat_t    stat_i,
  output zst_pkg::ctrl_cmd_t   cmd_o
);

  typedef enum logic [2:0] {
    S_INIT, S_IDLE, S_DIV, S_SWEEP, S_APPLY, S_READ, S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = (state_q == S_IDLE) && in_valid_i;
    cmd_o.div_step    = (state_q == S_DIV);
    cmd_o.sweep_start = (state_q == S_DIV) && stat_i.div_done &&
                        (stat_i.sa_all || (stat_i.act && stat_i.need_sweep));
    cmd_o.sweep_step  = (state_q == S_SWEEP) || (state_q == S_INIT);
    cmd_o.apply       = (state_q == S_APPLY);
    cmd_o.read        = (state_q == S_READ);
    cmd_o.emit        = (state_q == S_RESULT) && (!out_valid_q || out_ready_i);
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end
    case (state_q)
      S_INIT: begin
        if (stat_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DIV;
      end
      S_DIV: begin
        if (stat_i.div_done) state_d = cmd_o.sweep_start ? S_SWEEP : S_APPLY;
      end
      S_SWEEP: begin
        if (stat_i.sweep_done) state_d = S_APPLY;
      end
      S_APPLY:  state_d = S_READ;
      S_READ:   state_d = S_RESULT;
      S_RESULT: begin
        if (cmd_o.emit) state_d = S_IDLE;
      end
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

@@ hdl/zst_dp.sv @@
// Datapath of the zone table: configuration, zone tables, block map,
// zone divider, sweep unit and result register. Uses zst_pkg.
module zst_dp #(
  parameter int MAP_ENTRIES = zst_pkg::MapEntriesDef,
  parameter int MAX_ZONES   = zst_pkg::MaxZonesDef,
  parameter int TAG_BITS    = zst_pkg::TagBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [12:0]        cfg_data_i,
  input  zst_pkg::req_t      req_i,
  input  zst_pkg::ctrl_cmd_t cmd_i,
  output zst_pkg::dp_stat_t  stat_o,
  output zst_pkg::rsp_t      rsp_o
);

  localparam int MAW      = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
  localparam int PW       = $clog2(MAP_ENTRIES + 1);
  localparam int SUMW     = ((PW > 13) ? PW : 13) + 1;
  localparam int ZW       = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
  localparam int SweepAll = (MAP_ENTRIES > MAX_ZONES) ? MAP_ENTRIES : MAX_ZONES;
  localparam int DCW      = $clog2(zst_pkg::AddrBits + 1);
  localparam logic [SUMW-1:0] MapLim   = SUMW'(MAP_ENTRIES);
  localparam logic [SUMW-1:0] ZoneLim  = SUMW'(MAX_ZONES);
  localparam logic [DCW-1:0]  DivSteps = DCW'(zst_pkg::AddrBits);

  typedef enum logic [1:0] {SW_ALL, SW_CLEAR, SW_APPEND} sweep_mode_e;

  function automatic logic [PW-1:0] sat_pw(input logic [SUMW-1:0] v);
    logic [SUMW-1:0] s;
    s = (v > MapLim) ? MapLim : v;
    return s[PW-1:0];
  endfunction

  // Configuration registers.
  logic [12:0] zone_blocks_q;
  logic [4:0]  zone_count_q;

  // Latched request.
  zst_pkg::opcode_e op_q;
  logic                sa_q;
  logic [11:0]         addr_q;
  logic [3:0]          zi_q;
  logic [12:0]         cnt_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [12:0]         zb_q;
  logic [31:0]         tag_in;

  // Divider.
  logic [12:0]    rem_q;
  logic [11:0]    quo_q;
  logic [DCW-1:0] div_cnt_q;
  logic [13:0]    trial;
  logic           fits;

  // Sweep unit.
  sweep_mode_e     mode_q;
  logic [SUMW-1:0] ptr_q, end_q;
  logic [PW-1:0]   acc_q, blk_q;

  // Zone tables and block map.
  logic [2:0]          zs_q [MAX_ZONES];
  logic [PW-1:0]       bp_q [MAX_ZONES];
  logic [PW-1:0]       zp_q [MAX_ZONES];
  logic [1:0]          mk_mem [MAP_ENTRIES];
  logic [PW-1:0]       mb_mem [MAP_ENTRIES];
  logic [TAG_BITS-1:0] mt_mem [MAP_ENTRIES];
  logic [1:0]          mk_rd_q;
  logic [PW-1:0]       mb_rd_q;
  logic [TAG_BITS-1:0] mt_rd_q;

  // Decode.
  logic [12:0]     zone_w, zc;
  logic [ZW-1:0]   zidx;
  logic [SUMW-1:0] addr_s;
  logic            zone_ok, addr_ok, sa_all, sweeping;
  logic [1:0]      status;
  logic [2:0]      zs_cur;
  logic [PW-1:0]   bp_cur, zp_cur;

  // Map write port.
  logic                mk_we, mb_we, mt_we;
  logic [MAW-1:0]      widx;
  logic [1:0]          mk_wd;
  logic [PW-1:0]       mb_wd;
  logic [TAG_BITS-1:0] mt_wd;

  // Result formatting.
  logic [SUMW-1:0] bp_ext, zp_ext, mb_ext;
  logic [31:0]     mt_ext;

  assign tag_in = 32'(req_i.buffer_tag);
  assign trial  = {rem_q, quo_q[11]};
  assign fits   = trial >= {1'b0, zb_q};

  assign zone_w  = (op_q == zst_pkg::OP_APPEND_ZONE) ? 13'(zi_q) : {1'b0, quo_q};
  assign zc      = (32'(zone_count_q) > MAX_ZONES) ? 13'(MAX_ZONES) : 13'(zone_count_q);
  assign zone_ok = zone_w < zc;
  assign zidx    = zone_w[ZW-1:0];
  assign addr_s  = SUMW'(addr_q);
  assign addr_ok = addr_s < MapLim;
  assign sa_all  = (op_q == zst_pkg::OP_RESET) && sa_q;
  assign zs_cur  = zs_q[zidx];
  assign bp_cur  = bp_q[zidx];
  assign zp_cur  = zp_q[zidx];
  assign sweeping = cmd_i.sweep_step && (ptr_q < end_q);

  always_comb begin
    if (sa_all) begin
      status = zst_pkg::STATUS_OK;
    end else if ((op_q == zst_pkg::OP_APPEND_BUF) && (tag_q == '0)) begin
      status = zst_pkg::STATUS_NO_TAG;
    end else if (!(zone_ok && addr_ok)) begin
      status = zst_pkg::STATUS_RANGE;
    end else begin
      status = zst_pkg::STATUS_OK;
    end
  end

  assign stat_o.div_done   = (div_cnt_q == DivSteps);
  assign stat_o.sweep_done = !(ptr_q < end_q);
  assign stat_o.sa_all     = sa_all;
  assign stat_o.act        = (status == zst_pkg::STATUS_OK) && !sa_all;
  assign stat_o.need_sweep = (op_q == zst_pkg::OP_RESET) || (op_q == zst_pkg::OP_APPEND_ZONE);

  // Configuration, request capture, divider and sweep control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zone_blocks_q <= zst_pkg::RESET_ZONE_BLOCKS;
      zone_count_q  <= zst_pkg::RESET_ZONE_COUNT;
      zb_q          <= zst_pkg::RESET_ZONE_BLOCKS;
      div_cnt_q     <= '0;
      mode_q        <= SW_ALL;
      ptr_q         <= '0;
      end_q         <= SUMW'(SweepAll);
      acc_q         <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          zst_pkg::CFG_ZONE_BLOCKS: zone_blocks_q <= cfg_data_i;
          zst_pkg::CFG_ZONE_COUNT:  zone_count_q  <= cfg_data_i[4:0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        zb_q      <= (zone_blocks_q == '0) ? 13'd1 : zone_blocks_q;
        div_cnt_q <= '0;
      end else if (cmd_i.div_step && (div_cnt_q != DivSteps)) begin
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      if (cmd_i.sweep_start) begin
        if (sa_all) begin
          mode_q <= SW_ALL;
          ptr_q  <= '0;
          end_q  <= SUMW'(SweepAll);
          acc_q  <= '0;
        end else if (op_q == zst_pkg::OP_RESET) begin
          mode_q <= SW_CLEAR;
          ptr_q  <= addr_s;
          end_q  <= SUMW'(sat_pw(addr_s + SUMW'(zb_q)));
        end else begin
          mode_q <= SW_APPEND;
          ptr_q  <= addr_s;
          end_q  <= SUMW'(sat_pw(addr_s + SUMW'(cnt_q)));
        end
      end else if (sweeping) begin
        ptr_q <= ptr_q + 1'b1;
        acc_q <= sat_pw(SUMW'(acc_q) + SUMW'(zb_q));
      end
    end
  end

  // Payload registers: request fields, divider data, append block number.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= zst_pkg::opcode_e'(req_i.opcode);
      sa_q   <= req_i.all_zones;
      addr_q <= req_i.block_addr;
      zi_q   <= req_i.zone_index;
      cnt_q  <= req_i.block_count;
      tag_q  <= tag_in[TAG_BITS-1:0];
      rem_q  <= '0;
      quo_q  <= req_i.block_addr;
    end else if (cmd_i.div_step && (div_cnt_q != DivSteps)) begin
      rem_q <= fits ? 13'(trial - {1'b0, zb_q}) : trial[12:0];
      quo_q <= {quo_q[10:0], fits};
    end
    if (cmd_i.sweep_start) begin
      blk_q <= zp_cur;
    end else if (sweeping) begin
      blk_q <= sat_pw(SUMW'(blk_q) + SUMW'(1));
    end
  end

  // Zone tables: filled by the select-all sweep, updated by commands.
  always_ff @(posedge clk_i) begin
    if (sweeping && (mode_q == SW_ALL) && (ptr_q < ZoneLim)) begin
      zs_q[ptr_q[ZW-1:0]] <= zst_pkg::ZS_EMPTY;
      bp_q[ptr_q[ZW-1:0]] <= acc_q;
      zp_q[ptr_q[ZW-1:0]] <= acc_q;
    end
    if (cmd_i.apply && stat_o.act) begin
      case (op_q)
        zst_pkg::OP_RESET: begin
          zs_q[zidx] <= zst_pkg::ZS_EMPTY;
          bp_q[zidx] <= addr_s[PW-1:0];
          zp_q[zidx] <= addr_s[PW-1:0];
        end
        zst_pkg::OP_OPEN_IMP: zs_q[zidx] <= zst_pkg::ZS_OPEN_IMP;
        zst_pkg::OP_OPEN_EXP: begin
          if (!sa_q) zs_q[zidx] <= zst_pkg::ZS_OPEN_EXP;
        end
        zst_pkg::OP_CLOSE: begin
          if (!sa_q) zs_q[zidx] <= zst_pkg::ZS_CLOSED;
        end
        zst_pkg::OP_OFFLINE: begin
          if (!sa_q) zs_q[zidx] <= zst_pkg::ZS_OFFLINE;
        end
        zst_pkg::OP_FINISH: begin
          if (!sa_q) begin
            zs_q[zidx] <= zst_pkg::ZS_FULL;
            zp_q[zidx] <= sat_pw(addr_s + SUMW'(zb_q));
          end
        end
        zst_pkg::OP_APPEND_BUF:
          bp_q[zidx] <= sat_pw(SUMW'(bp_cur) + SUMW'(cnt_q));
        zst_pkg::OP_APPEND_ZONE:
          zp_q[zidx] <= sat_pw(SUMW'(zp_cur) + SUMW'(cnt_q));
        default: ;
      endcase
    end
  end

  // Single write port of the block map.
  always_comb begin
    mk_we = 1'b0;
    mb_we = 1'b0;
    mt_we = 1'b0;
    widx  = ptr_q[MAW-1:0];
    mk_wd = zst_pkg::KIND_UNUSED;
    mb_wd = '0;
    mt_wd = '0;
    if (sweeping) begin
      case (mode_q)
        SW_ALL: begin
          mk_we = ptr_q < MapLim;
          mb_we = ptr_q < MapLim;
          mt_we = ptr_q < MapLim;
        end
        SW_CLEAR: begin
          mk_we = 1'b1;
          mb_we = 1'b1;
          mt_we = 1'b1;
        end
        SW_APPEND: begin
          mk_we = 1'b1;
          mb_we = 1'b1;
          mk_wd = zst_pkg::KIND_ZONE;
          mb_wd = blk_q;
        end
        default: ;
      endcase
    end else if (cmd_i.apply && stat_o.act) begin
      widx = addr_s[MAW-1:0];
      case (op_q)
        zst_pkg::OP_APPEND_BUF: begin
          mk_we = 1'b1;
          mt_we = 1'b1;
          mk_wd = zst_pkg::KIND_BUFFER;
          mt_wd = tag_q;
        end
        zst_pkg::OP_APPEND_ZONE: mt_we = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mk_we) mk_mem[widx] <= mk_wd;
    if (mb_we) mb_mem[widx] <= mb_wd;
    if (mt_we) mt_mem[widx] <= mt_wd;
    if (cmd_i.read) begin
      mk_rd_q <= mk_mem[addr_s[MAW-1:0]];
      mb_rd_q <= mb_mem[addr_s[MAW-1:0]];
      mt_rd_q <= mt_mem[addr_s[MAW-1:0]];
    end
  end

  assign bp_ext = SUMW'(bp_cur);
  assign zp_ext = SUMW'(zp_cur);
  assign mb_ext = SUMW'(mb_rd_q);
  assign mt_ext = 32'(mt_rd_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_o.status         <= status;
      rsp_o.zone_state     <= zone_ok ? zs_cur : 3'd0;
      rsp_o.buffer_pointer <= zone_ok ? bp_ext[12:0] : 13'd0;
      rsp_o.zone_pointer   <= zone_ok ? zp_ext[12:0] : 13'd0;
      rsp_o.entry_kind     <= addr_ok ? mk_rd_q : zst_pkg::KIND_UNUSED;
      rsp_o.entry_block    <= addr_ok ? mb_ext[12:0] : 13'd0;
      rsp_o.entry_tag      <= addr_ok ? mt_ext[15:0] : 16'd0;
    end
  end

endmodule

@@ hdl/zoned_storage_zone_table.sv @@
// After acceptance a request passes the divider, an update, a map read and the
// result; a zone reset or zone append sweeps each map entry it touches between
// the divider and the update, a select-all reset sweeps max(MAP_ENTRIES,
// MAX_ZONES) entries. One request at a time: a new one is taken only when the
// controller is idle. Reset: asynchronous, active low; afterwards a clearing
// pass over max(MAP_ENTRIES, MAX_ZONES) entries runs before any request.
module zoned_storage_zone_table #(
  parameter int MAP_ENTRIES = zst_pkg::MapEntriesDef,
  parameter int MAX_ZONES   = zst_pkg::MaxZonesDef,
  parameter int TAG_BITS    = zst_pkg::TagBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [12:0] cfg_data_i,
  zst_stream_if.sink   req_i,
  zst_stream_if.source rsp_o
);

  // The controller walks each request through the datapath. The datapath
  // holds the zone tables in flip-flops and the block map in memory; a
  // finished result waits in the last controller state while the result
  // register still holds an earlier one that has not been taken.
  zst_pkg::ctrl_cmd_t cmd;
  zst_pkg::dp_stat_t  stat;
  logic               in_ready;
  logic               out_valid;
  zst_pkg::rsp_t      rsp;

  zst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath captures the request on load, divides the start block by
  // the zone size, sweeps the map where needed, and then updates a zone entry.
  zst_dp #(
    .MAP_ENTRIES (MAP_ENTRIES),
    .MAX_ZONES   (MAX_ZONES),
    .TAG_BITS    (TAG_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i.data),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .rsp_o      (rsp)
  );

  assign req_i.ready = in_ready;
  assign rsp_o.valid = out_valid;
  assign rsp_o.data  = rsp;

endmodule

@@ hdl/zst_checker.sv @@
// Port-level checks of the zone table, bound to the top level.
// Depends on zst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module zst_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          out_valid,
  input logic          out_ready,
  input zst_pkg::rsp_t rsp
);

  `ZST_ASSERT(a_status_code, out_valid |-> (rsp.status == zst_pkg::STATUS_OK || rsp.status == zst_pkg::STATUS_NO_TAG || rsp.status == zst_pkg::STATUS_RANGE), "unknown status code")
  `ZST_ASSERT(a_zone_state, out_valid |-> (rsp.zone_state <= zst_pkg::ZS_OFFLINE), "zone state out of range")
  `ZST_ASSERT(a_entry_kind, out_valid |-> (rsp.entry_kind == zst_pkg::KIND_UNUSED || rsp.entry_kind == zst_pkg::KIND_BUFFER || rsp.entry_kind == zst_pkg::KIND_ZONE), "unknown entry kind")
  `ZST_ASSERT(a_hold, (out_valid && !out_ready) |=> (out_valid && $stable(rsp)), "stalled result changed")

endmodule

bind zoned_storage_zone_table zst_checker u_zst_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (rsp_o.valid),
  .out_ready (rsp_o.ready),
  .rsp       (rsp_o.data)
);
